FILE: rtl/shared_memory_race_detector_unit_assert.svh
// Assertion macros shared by the race detector RTL.
`ifndef SHARED_MEMORY_RACE_DETECTOR_UNIT_ASSERT_SVH
`define SHARED_MEMORY_RACE_DETECTOR_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define SMRD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("smrd assertion failed");
// Next-cycle implication, disabled while reset is asserted.
`define SMRD_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("smrd assertion failed");
`else
`define SMRD_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define SMRD_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

FILE: rtl/smrd_pkg.sv
// Package of the race detector: defaults, mode codes, states and control structs.
`timescale 1ns / 1ps
package smrd_pkg;

    localparam int SMRD_DEPTH       = 1024;
    localparam int SMRD_THREAD_BITS = 16;
    localparam int SMRD_GROUP_BITS  = 16;

    typedef enum logic [1:0] {
        MODE_READ   = 2'd0,
        MODE_WRITE  = 2'd1,
        MODE_LOCAL  = 2'd2,
        MODE_GLOBAL = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        ST_WIPE,
        ST_IDLE,
        ST_LOCAL,
        ST_LTAIL,
        ST_FETCH,
        ST_EXEC,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic load_item;
        logic cnt_clr;
        logic wipe;
        logic sweep_rd;
        logic fetch_rd;
        logic exec;
        logic finish;
    } t_ctrl_cmd;

    typedef struct packed {
        t_mode in_mode;
        logic  in_access_ok;
        logic  cnt_last;
        logic  out_free;
    } t_dp_status;

endpackage

FILE: rtl/smrd_ram.sv
// Generic simple dual-port RAM with registered read data.
`timescale 1ns / 1ps
module smrd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/smrd_datapath.sv
// Datapath: item registers, sweep counter, shadow table, race check and result register.
`timescale 1ns / 1ps
module smrd_datapath
    import smrd_pkg::*;
#(
    parameter int DEPTH       = SMRD_DEPTH,
    parameter int THREAD_BITS = SMRD_THREAD_BITS,
    parameter int GROUP_BITS  = SMRD_GROUP_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [1:0]  i_mode,
    input  logic [9:0]  i_offset,
    input  logic [15:0] i_thread_id,
    input  logic [15:0] i_group_id,
    input  t_ctrl_cmd   i_cmd,
    output t_dp_status  o_status,
    input  logic        i_out_stall,
    output logic        o_out_valid,
    output logic        o_race,
    output logic        o_race_type,
    output logic [15:0] o_first_thread,
    output logic [15:0] o_second_thread
);

    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int TB   = THREAD_BITS;
    localparam int GB   = GROUP_BITS;
    localparam int EW   = TB + GB + 4;
    localparam int B_MG = 0;
    localparam int B_MR = 1;
    localparam int B_RD = 2;
    localparam int B_WR = 3;
    localparam int G_LO = 4;
    localparam int T_LO = GB + 4;

    // Incoming fields widened to 32 bits before trimming to the table widths.
    logic [31:0] in_ofs32, in_tid32, in_gid32;
    assign in_ofs32 = 32'(i_offset);
    assign in_tid32 = 32'(i_thread_id);
    assign in_gid32 = 32'(i_group_id);

    assign o_status.in_mode      = t_mode'(i_mode);
    assign o_status.in_access_ok = (in_tid32[TB-1:0] != '0) && (in_ofs32 < 32'(DEPTH));

    // Item registers.
    logic [AW-1:0] r_addr;
    logic [TB-1:0] r_tid;
    logic [GB-1:0] r_gid;
    logic          r_is_write;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_addr     <= in_ofs32[AW-1:0];
            r_tid      <= in_tid32[TB-1:0];
            r_gid      <= in_gid32[GB-1:0];
            r_is_write <= (t_mode'(i_mode) == MODE_WRITE);
        end
    end

    // Sweep counter and the write-back that follows each sweep read in the next cycle.
    logic [AW-1:0] r_cnt, n_cnt;
    logic [AW-1:0] r_wb_addr;
    logic          r_pend;

    always_comb begin
        n_cnt = r_cnt;
        if (i_cmd.cnt_clr) begin
            n_cnt = '0;
        end else if (i_cmd.wipe || i_cmd.sweep_rd) begin
            n_cnt = r_cnt + AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_pend <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_pend <= i_cmd.sweep_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.sweep_rd) begin
            r_wb_addr <= r_cnt;
        end
    end

    assign o_status.cnt_last = (r_cnt == AW'(DEPTH - 1));

    // Shadow table.
    logic [EW-1:0] rd_data, wr_data;
    logic [AW-1:0] wr_addr, rd_addr;
    logic          we, re;

    smrd_ram #(
        .WIDTH (EW),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_re    (re),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    assign re      = i_cmd.sweep_rd || i_cmd.fetch_rd;
    assign rd_addr = i_cmd.sweep_rd ? r_cnt : r_addr;

    // Fields of the entry that was read.
    logic [TB-1:0] e_thr;
    logic [GB-1:0] e_grp;
    logic          e_wr, e_rd, e_mr, e_mg;
    assign e_thr = rd_data[EW-1:T_LO];
    assign e_grp = rd_data[T_LO-1:G_LO];
    assign e_wr  = rd_data[B_WR];
    assign e_rd  = rd_data[B_RD];
    assign e_mr  = rd_data[B_MR];
    assign e_mg  = rd_data[B_MG];

    // Local reset of one entry: if its group matches, clear its thread and the many-readers mark.
    logic [EW-1:0] local_entry;
    always_comb begin
        local_entry = rd_data;
        if (e_grp == r_gid) begin
            local_entry[EW-1:T_LO] = '0;
            local_entry[B_MR]      = 1'b0;
        end
    end

    // Race check and updated entry for one access.
    logic          match, race, race_type;
    logic [TB-1:0] first_thr, second_thr;
    logic [EW-1:0] acc_entry;

    always_comb begin
        match     = (e_thr == r_tid) || (e_grp == r_gid);
        acc_entry = rd_data;
        acc_entry[EW-1:T_LO]   = r_tid;
        acc_entry[T_LO-1:G_LO] = r_gid;
        if (r_is_write) begin
            race       = e_mr || e_mg || ((e_rd || e_wr) && !match);
            race_type  = !e_rd;
            first_thr  = e_thr;
            second_thr = r_tid;
            acc_entry[B_WR] = 1'b1;
        end else begin
            race       = e_wr && !match;
            race_type  = 1'b0;
            first_thr  = r_tid;
            second_thr = e_thr;
            acc_entry[B_RD] = 1'b1;
            acc_entry[B_MR] = e_mr || (e_rd && (e_thr != '0) && (e_thr != r_tid));
            acc_entry[B_MG] = e_mg || (e_rd && (e_grp != r_gid));
        end
    end

    always_comb begin
        if (i_cmd.wipe) begin
            we      = 1'b1;
            wr_addr = r_cnt;
            wr_data = '0;
        end else if (r_pend) begin
            we      = 1'b1;
            wr_addr = r_wb_addr;
            wr_data = local_entry;
        end else begin
            we      = i_cmd.exec && !race;
            wr_addr = r_addr;
            wr_data = acc_entry;
        end
    end

    // Result register.
    logic        r_out_valid;
    logic        r_race, r_race_type;
    logic [15:0] r_first, r_second;
    logic [31:0] first32, second32;

    assign first32  = 32'(first_thr);
    assign second32 = 32'(second_thr);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.exec || i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && race) begin
            r_race      <= 1'b1;
            r_race_type <= race_type;
            r_first     <= first32[15:0];
            r_second    <= second32[15:0];
        end else if (i_cmd.exec || i_cmd.finish) begin
            r_race      <= 1'b0;
            r_race_type <= 1'b0;
            r_first     <= '0;
            r_second    <= '0;
        end
    end

    assign o_status.out_free = !r_out_valid || !i_out_stall;

    assign o_out_valid     = r_out_valid;
    assign o_race          = r_race;
    assign o_race_type     = r_race_type;
    assign o_first_thread  = r_first;
    assign o_second_thread = r_second;

endmodule

FILE: rtl/smrd_ctrl.sv
// Controller state machine: sequences accesses, table sweeps and result loading.
`timescale 1ns / 1ps
module smrd_ctrl
    import smrd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_dp_status i_status,
    output t_ctrl_cmd  o_cmd
);

    t_state r_state, n_state;
    logic   r_report, n_report;
    logic   ready, accept;

    // A beat is taken in IDLE, or in EXEC or FINISH when the result slot is free.
    always_comb begin
        case (r_state)
            ST_IDLE:   ready = 1'b1;
            ST_EXEC:   ready = i_status.out_free;
            ST_FINISH: ready = i_status.out_free;
            default:   ready = 1'b0;
        endcase
    end

    assign accept     = ready && i_in_valid;
    assign o_in_stall = !ready;

    always_comb begin
        n_state  = r_state;
        n_report = r_report;
        case (r_state)
            ST_WIPE: begin
                if (i_status.cnt_last) begin
                    n_state = r_report ? ST_FINISH : ST_IDLE;
                end
            end
            ST_LOCAL: begin
                if (i_status.cnt_last) begin
                    n_state = ST_LTAIL;
                end
            end
            ST_LTAIL: begin
                n_state = ST_FINISH;
            end
            ST_FETCH: begin
                n_state = ST_EXEC;
            end
            ST_IDLE, ST_EXEC, ST_FINISH: begin
                if (ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        if (accept) begin
            case (i_status.in_mode)
                MODE_GLOBAL: begin
                    n_state  = ST_WIPE;
                    n_report = 1'b1;
                end
                MODE_LOCAL: begin
                    n_state = ST_LOCAL;
                end
                default: begin
                    n_state = i_status.in_access_ok ? ST_FETCH : ST_FINISH;
                end
            endcase
        end
    end

    always_comb begin
        o_cmd           = '0;
        o_cmd.load_item = accept;
        o_cmd.cnt_clr   = accept;
        case (r_state)
            ST_WIPE:   o_cmd.wipe     = 1'b1;
            ST_LOCAL:  o_cmd.sweep_rd = 1'b1;
            ST_FETCH:  o_cmd.fetch_rd = 1'b1;
            ST_EXEC:   o_cmd.exec     = i_status.out_free;
            ST_FINISH: o_cmd.finish   = i_status.out_free;
            default:   o_cmd.wipe     = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_WIPE;
            r_report <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_report <= n_report;
        end
    end

endmodule

FILE: rtl/shared_memory_race_detector_unit.sv
// Top level of the shared-memory race detector: controller, datapath and checks.
`timescale 1ns / 1ps
// The block keeps a shadow entry for every byte offset of one tracked object and checks
// each read or write beat against it. Input beats (mode, offset, thread, group) arrive
// on i_in_valid / o_in_stall; one result beat per input leaves on o_out_valid /
// i_out_stall. A beat moves when valid is high and stall is low.
// Read and write accesses pass through a table read state (ST_FETCH) and then a check
// state (ST_EXEC) that checks, writes back if there is no race and loads the result
// register. The next beat is taken in that check state when the result register is free,
// so back-to-back accesses overlap and a new beat is taken before the last one is done.
// Accesses from thread 0 or beyond the table skip the table and report no race.
// A local workgroup reset sweeps the table read-modify-write, one entry a cycle, and
// then reports. A global reset writes zeros over the table and then reports.
// After i_rst_n the same clearing pass runs with no input taken and
// no result given. When the receiver stalls, the result register holds its beat; one
// more input beat may be taken behind it, and its result waits until the register frees.
module shared_memory_race_detector_unit
    import smrd_pkg::*;
#(
    parameter int DEPTH       = SMRD_DEPTH,
    parameter int THREAD_BITS = SMRD_THREAD_BITS,
    parameter int GROUP_BITS  = SMRD_GROUP_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_mode,
    input  logic [9:0]  i_offset,
    input  logic [15:0] i_thread_id,
    input  logic [15:0] i_group_id,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_race,
    output logic        o_race_type,
    output logic [15:0] o_first_thread,
    output logic [15:0] o_second_thread
);

`include "shared_memory_race_detector_unit_assert.svh"

    // Commands from the controller and status back from the datapath.
    t_ctrl_cmd  cmd;
    t_dp_status status;

    smrd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    smrd_datapath #(
        .DEPTH       (DEPTH),
        .THREAD_BITS (THREAD_BITS),
        .GROUP_BITS  (GROUP_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_mode          (i_mode),
        .i_offset        (i_offset),
        .i_thread_id     (i_thread_id),
        .i_group_id      (i_group_id),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_race          (o_race),
        .o_race_type     (o_race_type),
        .o_first_thread  (o_first_thread),
        .o_second_thread (o_second_thread)
    );

    // Table and result operations of this cycle, and whether the result carries zeros.
    logic [4:0] ops;
    logic       out_zero;
    assign ops      = {cmd.wipe, cmd.sweep_rd, cmd.fetch_rd, cmd.exec, cmd.finish};
    assign out_zero = !o_race_type && (o_first_thread == 16'd0) && (o_second_thread == 16'd0);

    // At most one table or result operation is commanded in any cycle.
    `SMRD_ASSERT_IMP(a_one_op, i_clk, i_rst_n, 1'b1, $onehot0(ops))
    // A result is never loaded over one the receiver has not taken.
    `SMRD_ASSERT_IMP(a_load_free, i_clk, i_rst_n, cmd.exec || cmd.finish, status.out_free)
    // The check follows the table read directly unless the result register is blocked.
    `SMRD_ASSERT_NXT(a_fetch_exec, i_clk, i_rst_n, cmd.fetch_rd, cmd.exec || !status.out_free)
    // A beat without a race carries zero thread ids and type.
    `SMRD_ASSERT_IMP(a_no_race_zero, i_clk, i_rst_n, o_out_valid && !o_race, out_zero)

endmodule

FILE: bench/shared_memory_race_detector_unit_test.sv
// Self-checking testbench for the shared-memory race detector: directed table, then random bursts.
`timescale 1ns / 1ps
module shared_memory_race_detector_unit_test
    import smrd_pkg::*;
;

    // Race type codes as the block reports them.
    localparam logic RW_RACE = 1'b0;
    localparam logic WW_RACE = 1'b1;

    localparam int N_DIRECTED   = 23;
    localparam int RANDOM_BEATS = 900;
    localparam int MAX_REPORTS  = 10;

    // One input beat as the block sees it.
    typedef struct packed {
        t_mode       mode;
        logic [9:0]  offset;
        logic [15:0] thread_id;
        logic [15:0] group_id;
    } access_t;

    // One result beat.
    typedef struct packed {
        logic        race;
        logic        race_type;
        logic [15:0] first_thread;
        logic [15:0] second_thread;
    } verdict_t;

    // A row of the directed table. When typed is set, want is the expected result;
    // otherwise the result comes from the shadow-table predictor.
    typedef struct packed {
        access_t  acc;
        logic     typed;
        verdict_t want;
    } row_t;

    localparam verdict_t NO_RACE = '{1'b0, RW_RACE, 16'd0, 16'd0};

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [1:0]  i_mode;
    logic [9:0]  i_offset;
    logic [15:0] i_thread_id;
    logic [15:0] i_group_id;
    logic        o_out_valid;
    logic        i_out_stall;
    logic        o_race;
    logic        o_race_type;
    logic [15:0] o_first_thread;
    logic [15:0] o_second_thread;

    shared_memory_race_detector_unit DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_mode          (i_mode),
        .i_offset        (i_offset),
        .i_thread_id     (i_thread_id),
        .i_group_id      (i_group_id),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_race          (o_race),
        .o_race_type     (o_race_type),
        .o_first_thread  (o_first_thread),
        .o_second_thread (o_second_thread)
    );

    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Shadow copy of the block's table. Everything starts at zero, which is also
    // the state that the clearing pass after reset leaves behind.
    bit [15:0] shadow_thread    [SMRD_DEPTH];
    bit [15:0] shadow_group     [SMRD_DEPTH];
    bit        shadow_rd        [SMRD_DEPTH];
    bit        shadow_wr        [SMRD_DEPTH];
    bit        shadow_multi_thr [SMRD_DEPTH];
    bit        shadow_multi_grp [SMRD_DEPTH];

    verdict_t expected_verdicts [$];
    int       mismatch_count;
    bit       steady;

    // Directed table. It first walks the races that can be read straight off the
    // rules: a write over another thread's read, a read over a foreign write, and a
    // write over a foreign write. Then it builds up the several-readers and
    // several-workgroups marks on one entry, shows that a local reset clears only
    // the thread part of that history, and ends with a global reset that forgets
    // everything. Thread-zero beats and the extreme offsets and ids are mixed in.
    row_t directed_rows [N_DIRECTED] = '{
        '{'{MODE_READ,   10'd0,    16'h0001, 16'h0001}, 1'b1, NO_RACE},
        '{'{MODE_WRITE,  10'd0,    16'h0002, 16'h0002}, 1'b1,
          '{1'b1, RW_RACE, 16'h0001, 16'h0002}},
        '{'{MODE_WRITE,  10'd1,    16'hFFFF, 16'hFFFF}, 1'b1, NO_RACE},
        '{'{MODE_READ,   10'd1,    16'h0001, 16'h0000}, 1'b1,
          '{1'b1, RW_RACE, 16'h0001, 16'hFFFF}},
        '{'{MODE_WRITE,  10'd1,    16'h0002, 16'h0000}, 1'b1,
          '{1'b1, WW_RACE, 16'hFFFF, 16'h0002}},
        '{'{MODE_READ,   10'd1,    16'h0000, 16'h0000}, 1'b1, NO_RACE},
        '{'{MODE_WRITE,  10'd1,    16'h0000, 16'hFFFF}, 1'b1, NO_RACE},
        '{'{MODE_WRITE,  10'h3FF,  16'h8000, 16'h5555}, 1'b1, NO_RACE},
        '{'{MODE_WRITE,  10'h3FF,  16'h0001, 16'h5555}, 1'b0, NO_RACE},
        '{'{MODE_READ,   10'h3FF,  16'h7FFF, 16'hAAAA}, 1'b1,
          '{1'b1, RW_RACE, 16'h7FFF, 16'h0001}},
        '{'{MODE_READ,   10'h3FF,  16'h0001, 16'h0000}, 1'b0, NO_RACE},
        '{'{MODE_READ,   10'd5,    16'h0003, 16'h0007}, 1'b0, NO_RACE},
        '{'{MODE_READ,   10'd5,    16'h0004, 16'h0007}, 1'b0, NO_RACE},
        '{'{MODE_READ,   10'd5,    16'h0005, 16'h0008}, 1'b0, NO_RACE},
        '{'{MODE_WRITE,  10'd5,    16'h0005, 16'h0008}, 1'b0, NO_RACE},
        '{'{MODE_LOCAL,  10'h3FF,  16'hFFFF, 16'h0008}, 1'b1, NO_RACE},
        '{'{MODE_WRITE,  10'd5,    16'h0009, 16'h0008}, 1'b0, NO_RACE},
        '{'{MODE_READ,   10'd6,    16'h0003, 16'h0007}, 1'b0, NO_RACE},
        '{'{MODE_LOCAL,  10'd0,    16'h0000, 16'h0007}, 1'b1, NO_RACE},
        '{'{MODE_READ,   10'd6,    16'h0002, 16'h0009}, 1'b0, NO_RACE},
        '{'{MODE_GLOBAL, 10'h2AA,  16'h5555, 16'hAAAA}, 1'b1, NO_RACE},
        '{'{MODE_WRITE,  10'd5,    16'h0009, 16'h0008}, 1'b1, NO_RACE},
        '{'{MODE_READ,   10'd0,    16'h0001, 16'h0001}, 1'b1, NO_RACE}
    };

    // Appends one expectation behind the ones still owed.
    function automatic void queue_verdict(input verdict_t v);
        expected_verdicts = {expected_verdicts, v};
    endfunction

    // Applies one beat to the shadow table and returns the result the block owes.
    // A race leaves the entry as it was; thread 0 is ignored.
    function automatic verdict_t predict_race(input access_t a);
        verdict_t v;
        logic     same_owner;
        int       o;
        v = NO_RACE;
        o = int'(a.offset);
        case (a.mode)
            MODE_GLOBAL: begin
                for (int i = 0; i < SMRD_DEPTH; i++) begin
                    shadow_thread[i]    = '0;
                    shadow_group[i]     = '0;
                    shadow_rd[i]        = 1'b0;
                    shadow_wr[i]        = 1'b0;
                    shadow_multi_thr[i] = 1'b0;
                    shadow_multi_grp[i] = 1'b0;
                end
            end
            MODE_LOCAL: begin
                for (int i = 0; i < SMRD_DEPTH; i++) begin
                    if (shadow_group[i] == a.group_id) begin
                        shadow_thread[i]    = '0;
                        shadow_multi_thr[i] = 1'b0;
                    end
                end
            end
            default: begin
                if (a.thread_id != 16'd0) begin
                    same_owner = (shadow_thread[o] == a.thread_id) ||
                                 (shadow_group[o] == a.group_id);
                    if (a.mode == MODE_READ) begin
                        if (shadow_wr[o] && !same_owner) begin
                            v.race          = 1'b1;
                            v.race_type     = RW_RACE;
                            v.first_thread  = a.thread_id;
                            v.second_thread = shadow_thread[o];
                        end else begin
                            if (shadow_rd[o]) begin
                                if (shadow_thread[o] != 16'd0 && shadow_thread[o] != a.thread_id) begin
                                    shadow_multi_thr[o] = 1'b1;
                                end
                                if (shadow_group[o] != a.group_id) begin
                                    shadow_multi_grp[o] = 1'b1;
                                end
                            end
                            shadow_thread[o] = a.thread_id;
                            shadow_group[o]  = a.group_id;
                            shadow_rd[o]     = 1'b1;
                        end
                    end else begin
                        if (shadow_multi_thr[o] || shadow_multi_grp[o] ||
                                ((shadow_rd[o] || shadow_wr[o]) && !same_owner)) begin
                            v.race          = 1'b1;
                            v.race_type     = shadow_rd[o] ? RW_RACE : WW_RACE;
                            v.first_thread  = shadow_thread[o];
                            v.second_thread = a.thread_id;
                        end else begin
                            shadow_thread[o] = a.thread_id;
                            shadow_group[o]  = a.group_id;
                            shadow_wr[o]     = 1'b1;
                        end
                    end
                end
            end
        endcase
        return v;
    endfunction

    // Drives one input beat. Called at a falling edge and returns at the falling edge
    // after the beat was taken, with valid still high; the next call either keeps it
    // high with a new payload or lowers it for a gap, never both in one step.
    task automatic send_beat(input access_t a, input logic typed, input verdict_t want);
        int       gap;
        verdict_t predicted;
        gap = steady ? 0 : $urandom_range(0, 6);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_mode      <= a.mode;
        i_offset    <= a.offset;
        i_thread_id <= a.thread_id;
        i_group_id  <= a.group_id;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        // The predictor always runs so that the shadow table tracks the block,
        // even on rows whose expected result is typed into the table.
        predicted = predict_race(a);
        queue_verdict(typed ? want : predicted);
        @(negedge i_clk);
    endtask

    // Lowers valid and waits at the falling edges until every result is back.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (expected_verdicts.size() != 0) @(negedge i_clk);
    endtask

    // Result checker. A beat leaves the block at a rising edge with valid high and
    // stall low, and is compared with the oldest expectation.
    always @(posedge i_clk) begin
        verdict_t got;
        verdict_t want;
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            got = '{o_race, o_race_type, o_first_thread, o_second_thread};
            if (expected_verdicts.size() == 0) begin
                if (mismatch_count < MAX_REPORTS) begin
                    $display("unexpected result beat: race %b type %b first %h second %h",
                             got.race, got.race_type, got.first_thread, got.second_thread);
                end
                mismatch_count++;
            end else begin
                want = expected_verdicts.pop_front();
                if (got !== want) begin
                    if (mismatch_count < MAX_REPORTS) begin
                        $display("result mismatch: race %b/%b type %b/%b first %h/%h second %h/%h",
                                 want.race, got.race, want.race_type, got.race_type,
                                 want.first_thread, got.first_thread,
                                 want.second_thread, got.second_thread);
                    end
                    mismatch_count++;
                end
            end
        end
    end

    // Receiver. Before each result it may hold stall high for a random hold, then
    // takes the next beat; during the steady stretch it never stalls.
    initial begin
        int hold;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            hold = steady ? 0 : $urandom_range(0, 6);
            if (hold != 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(negedge i_clk);
                i_out_stall <= 1'b0;
            end
            do @(posedge i_clk); while (o_out_valid !== 1'b1);
            @(negedge i_clk);
        end
    end

    // Stimulus. The random part is made of short bursts on one entry, mostly from
    // threads of one workgroup so that entries build real history (shared reads,
    // owner writes) instead of racing on the first foreign touch. Some beats come
    // from other workgroups, from wide random ids or from thread 0. Local resets
    // and, more rarely, global resets are slow table sweeps and so are kept sparse.
    initial begin
        access_t     acc;
        int          items;
        int          burst_len;
        int          pick;
        logic [9:0]  spot;
        logic [15:0] home_group;
        bit          drained;

        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_mode      = MODE_READ;
        i_offset    = '0;
        i_thread_id = '0;
        i_group_id  = '0;
        i_out_stall = 1'b0;
        mismatch_count = 0;
        steady  = 1'b0;
        drained = 1'b0;
        items   = 0;

        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int r = 0; r < N_DIRECTED; r++) begin
            send_beat(directed_rows[r].acc, directed_rows[r].typed, directed_rows[r].want);
        end

        while (items < RANDOM_BEATS) begin
            // Both sides run without gaps for a while, so back-to-back beats are seen.
            steady = (items >= 300 && items < 420);
            // Once, the sender stops until every result is back.
            if (!drained && items >= 450) begin
                drain_results();
                drained = 1'b1;
            end
            pick = $urandom_range(0, 99);
            acc.offset    = 10'($urandom);
            acc.thread_id = 16'($urandom);
            if (pick < 2) begin
                acc.mode     = MODE_GLOBAL;
                acc.group_id = 16'($urandom);
                send_beat(acc, 1'b0, NO_RACE);
                items++;
            end else if (pick < 10) begin
                acc.mode     = MODE_LOCAL;
                acc.group_id = ($urandom_range(0, 4) == 0) ? 16'($urandom)
                                                           : 16'($urandom_range(1, 6));
                send_beat(acc, 1'b0, NO_RACE);
                items++;
            end else begin
                // Most bursts land on a few entries at both ends of the table.
                case ($urandom_range(0, 3))
                    0:       spot = 10'($urandom);
                    1:       spot = 10'($urandom_range(1016, 1023));
                    default: spot = 10'($urandom_range(0, 7));
                endcase
                home_group = 16'($urandom_range(1, 6));
                burst_len  = $urandom_range(2, 6);
                for (int k = 0; k < burst_len; k++) begin
                    acc.mode   = ($urandom_range(0, 2) == 0) ? MODE_WRITE : MODE_READ;
                    acc.offset = spot;
                    pick = $urandom_range(0, 19);
                    if (pick == 0) begin
                        acc.thread_id = 16'd0;
                        acc.group_id  = 16'($urandom);
                    end else if (pick == 1) begin
                        acc.thread_id = 16'($urandom_range(1, 65535));
                        acc.group_id  = 16'($urandom);
                    end else if (pick < 4) begin
                        acc.group_id  = 16'($urandom_range(1, 6));
                        acc.thread_id = 16'(acc.group_id * 8 + $urandom_range(0, 3));
                    end else begin
                        acc.group_id  = home_group;
                        acc.thread_id = 16'(home_group * 8 + $urandom_range(0, 3));
                    end
                    send_beat(acc, 1'b0, NO_RACE);
                    // Thread-zero beats are ignored by the block and are not counted.
                    if (acc.thread_id != 16'd0) begin
                        items++;
                    end
                end
            end
        end

        steady = 1'b0;
        drain_results();
        repeat (16) @(posedge i_clk);
        if (mismatch_count == 0 && expected_verdicts.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Watchdog. It ends the run with a failure if the stimulus never finishes.
    initial begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+rtl
rtl/smrd_pkg.sv
rtl/smrd_ram.sv
rtl/smrd_datapath.sv
rtl/smrd_ctrl.sv
rtl/shared_memory_race_detector_unit.sv
bench/shared_memory_race_detector_unit_test.sv
